### sv/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared constants and a helper function for the double / extended converter.
// ----------------------------------------------------------------------------
package dfc_pkg;

	localparam logic        MODE_D2X    = 1'b0;
	localparam logic        MODE_X2D    = 1'b1;
	localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;
	localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;

	function automatic logic [5:0] msb_idx(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = i[5:0];
		end
		return p;
	endfunction

endpackage

### sv/dfc_d2x.sv
// ----------------------------------------------------------------------------
// dfc_d2x
// Double bit pattern to extended sign/exponent and mantissa.
// ----------------------------------------------------------------------------
module dfc_d2x (
	input  logic [63:0] d,
	output logic [15:0] se,
	output logic [63:0] mant
);
	import dfc_pkg::*;

	logic        sgn;
	logic [10:0] e;
	logic [51:0] f;
	logic [5:0]  p;

	always_comb begin
		sgn  = d[63];
		e    = d[62:52];
		f    = d[51:0];
		p    = msb_idx({12'd0, f});
		se   = '0;
		mant = '0;
		if (e == '0 && f == '0) begin
			se = '0;
		end else if (e == 11'h7FF) begin
			se = (f == '0) ? {sgn, EXT_EXP_MAX} : {1'b0, EXT_EXP_MAX};
		end else if (e != '0) begin
			se   = {sgn, 15'(e) + 15'd15360};
			mant = {1'b1, f, 11'd0};
		end else begin
			se   = {sgn, 15'(p) + 15'd15309};
			mant = {12'd0, f} << (6'd63 - p);
		end
	end

endmodule

### sv/dfc_x2d.sv
// ----------------------------------------------------------------------------
// dfc_x2d
// Extended sign/exponent and mantissa to double, round to nearest-even.
// ----------------------------------------------------------------------------
module dfc_x2d (
	input  logic [15:0] se,
	input  logic [63:0] m,
	output logic [63:0] d
);
	import dfc_pkg::*;

	logic        sgn;
	logic [14:0] ex;
	logic [5:0]  p;
	logic signed [17:0] u, lsb, s, bige;
	logic [63:0] q, rem, half, mask;
	logic [63:0] bits;
	logic        up;

	always_comb begin
		sgn  = se[15];
		ex   = se[14:0];
		p    = msb_idx(m);
		bige = $signed({3'd0, ex}) - 18'sd16446;
		u    = bige + $signed({12'd0, p});
		lsb  = (u - 18'sd52 > -18'sd1074) ? (u - 18'sd52) : -18'sd1074;
		s    = lsb - bige;
		q    = '0;
		rem  = '0;
		half = '0;
		mask = '0;
		up   = 1'b0;
		if (s <= 0) begin
			q = m << 6'(-s);
		end else if (s > 18'sd64) begin
			q = '0;
		end else if (s == 18'sd64) begin
			q = {63'd0, (m > 64'h8000_0000_0000_0000)};
		end else begin
			mask = (64'd1 << 6'(s)) - 64'd1;
			half = 64'd1 << 6'(s - 18'sd1);
			rem  = m & mask;
			q    = m >> 6'(s);
			up   = (rem > half) || (rem == half && q[0]);
			q    = q + {63'd0, up};
		end
		bits = {1'b0, 11'(lsb + 18'sd1074), 52'd0} + q;
		if (bits >= DBL_INF) bits = DBL_INF;
		if (ex == '0 && m == '0) d = '0;
		else if (ex == EXT_EXP_MAX) d = DBL_INF;
		else if (m == '0) d = {sgn, 63'd0};
		else if (u > 18'sd1023) d = {sgn, DBL_INF[62:0]};
		else d = {sgn, bits[62:0]};
	end

endmodule

### sv/double_extended_float_converter_unit.sv
// ----------------------------------------------------------------------------
// double_extended_float_converter_unit
// Converts between IEEE double and 80-bit extended values.
// ----------------------------------------------------------------------------
// One item per cycle; busy is always low. An accepted item is captured in the
// input registers, converted by single-pass logic, and its result is registered
// onto out_sign_exp/out_bits with done high for one cycle. The receiver cannot
// stall the output.
module double_extended_float_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] in_sign_exp,
	input  logic [63:0] in_bits,
	output logic        done,
	output logic [15:0] out_sign_exp,
	output logic [63:0] out_bits
);
	import dfc_pkg::*;

	logic        vld_s1, mode_s1;
	logic [15:0] se_s1;
	logic [63:0] bits_s1;
	logic [15:0] d2x_se;
	logic [63:0] d2x_m, x2d_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		se_s1   <= in_sign_exp;
		bits_s1 <= in_bits;
		if (mode_s1 == MODE_D2X) begin
			out_sign_exp <= d2x_se;
			out_bits     <= d2x_m;
		end else begin
			out_sign_exp <= '0;
			out_bits     <= x2d_d;
		end
	end

	dfc_d2x u_d2x (.d(bits_s1), .se(d2x_se), .mant(d2x_m));
	dfc_x2d u_x2d (.se(se_s1), .m(bits_s1), .d(x2d_d));

`ifndef SYNTH
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done) else $error("lost item");
	a_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> !done) else $error("spurious item");
	a_x2d_se: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && mode_s1 == MODE_X2D) |=> out_sign_exp == '0)
		else $error("nonzero sign/exp in mode 1");
`endif

endmodule
